// File: design/sha_pkg.sv
// Package: SHA-256 types, round constants and helper functions.
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] INIT_VALUE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: design/sha256_hasher.sv
// Top level: byte-serial SHA-256 hasher with one shared round unit.
// Bytes are taken one per transfer while no block is running; each full 64-byte block
// runs 64 rounds, one per cycle, and then folds into the chain value, during all of
// which req_stall is high. A last transfer pads (one pad byte at a time, then one or two
// blocks of rounds) and then presents the eight digest words on the rsp channel, one per
// transfer.
module sha256_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha_pkg::state_type state_ff, state_in;
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  widx_ff, widx_in;
   logic        final_ff, final_in;
   logic        padded_ff, padded_in;
   logic        spill_ff, spill_in;

   logic        req_xfer, rsp_xfer;
   logic        push;
   logic [7:0]  push_byte;
   logic [31:0] w_new, w_cur, t1, t2, e, a, s0, s1, w15, w2;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // outputs
   always_comb begin
      req_stall       = (state_ff != sha_pkg::ST_IDLE);
      rsp_valid       = (state_ff == sha_pkg::ST_EMIT);
      rsp_digest_word = chain_ff[widx_ff];
      rsp_word_index  = widx_ff;
      rsp_last_word   = (widx_ff == 3'd7);
   end

   // shared round unit
   always_comb begin
      w15   = win_ff[4'(round_ff - 6'd15)];
      w2    = win_ff[4'(round_ff - 6'd2)];
      s0    = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
      s1    = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
      w_new = win_ff[round_ff[3:0]] + s0 + win_ff[4'(round_ff - 6'd7)] + s1;
      w_cur = (round_ff < 6'd16) ? win_ff[round_ff[3:0]] : w_new;
      e     = work_ff[4];
      a     = work_ff[0];
      t1    = work_ff[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
            + ((e & work_ff[5]) ^ (~e & work_ff[6])) + sha_pkg::ROUND_K[round_ff] + w_cur;
      t2    = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
            + ((a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
   end

   // pad byte source; length bytes only in the block that does not spill past byte 55
   always_comb begin
      push      = 1'b0;
      push_byte = 8'h00;
      if (state_ff == sha_pkg::ST_IDLE && req_xfer && req_byte_valid) begin
         push      = 1'b1;
         push_byte = req_message_byte;
      end else if (state_ff == sha_pkg::ST_PAD) begin
         push = 1'b1;
         if (!padded_ff) push_byte = 8'h80;
         else if (!spill_ff && (fill_ff inside {[6'd56:6'd63]}))
            push_byte = len_ff[6'(63 - 8 * (fill_ff - 6'd56)) -: 8];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_byte_valid && fill_ff == 6'd63) state_in = sha_pkg::ST_ROUND;
               else if (req_last_byte) state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_ROUND: if (round_ff == 6'd63) state_in = sha_pkg::ST_FOLD;
         sha_pkg::ST_FOLD: begin
            if (final_ff && padded_ff && len_ff == 64'd0) state_in = sha_pkg::ST_EMIT;
            else if (final_ff) state_in = sha_pkg::ST_PAD;
            else state_in = sha_pkg::ST_IDLE;
         end
         sha_pkg::ST_PAD: if (fill_ff == 6'd63) state_in = sha_pkg::ST_ROUND;
         sha_pkg::ST_EMIT: if (rsp_xfer && widx_ff == 3'd7) state_in = sha_pkg::ST_IDLE;
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // datapath; len_ff is cleared once the length bytes are in to mark the tail block
   always_comb begin
      chain_in  = chain_ff;
      work_in   = work_ff;
      win_in    = win_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      len_in    = len_ff;
      round_in  = round_ff;
      widx_in   = widx_ff;
      final_in  = final_ff;
      padded_in = padded_ff;
      spill_in  = spill_ff;
      if (push) begin
         if (fill_ff[1:0] == 2'd0)
            win_in[fill_ff[5:2]] = {push_byte, 24'd0};
         else
            win_in[fill_ff[5:2]][5'(31 - 8 * fill_ff[1:0]) -: 8] = push_byte;
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            work_in  = chain_ff;
            round_in = 6'd0;
         end
      end
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_byte_valid) bits_in = bits_ff + 64'd8;
               if (req_last_byte) begin
                  final_in  = 1'b1;
                  padded_in = 1'b0;
                  len_in    = req_byte_valid ? bits_ff + 64'd8 : bits_ff;
               end
            end
         end
         sha_pkg::ST_ROUND: begin
            if (round_ff >= 6'd16) win_in[round_ff[3:0]] = w_new;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = e;
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = a;
            work_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
         end
         sha_pkg::ST_FOLD: begin
            for (int j = 0; j < 8; j++) chain_in[j] = chain_ff[j] + work_ff[j];
            widx_in = 3'd0;
         end
         sha_pkg::ST_PAD: begin
            padded_in = 1'b1;
            if (!padded_ff) spill_in = (fill_ff inside {[6'd56:6'd62]});
            else if (fill_ff == 6'd63) spill_in = 1'b0;
            if (fill_ff == 6'd63 && padded_ff && !spill_ff) len_in = 64'd0;
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  chain_in = sha_pkg::INIT_VALUE;
                  for (int j = 0; j < 8; j++) work_in[j] = 32'd0;
                  fill_in  = 6'd0;
                  bits_in  = 64'd0;
                  final_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha_pkg::ST_IDLE;
         chain_ff  <= sha_pkg::INIT_VALUE;
         for (int j = 0; j < 8; j++) work_ff[j] <= 32'd0;
         fill_ff   <= 6'd0;
         bits_ff   <= 64'd0;
         len_ff    <= 64'd0;
         round_ff  <= 6'd0;
         widx_ff   <= 3'd0;
         final_ff  <= 1'b0;
         padded_ff <= 1'b0;
         spill_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         chain_ff  <= chain_in;
         work_ff   <= work_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         len_ff    <= len_in;
         round_ff  <= round_in;
         widx_ff   <= widx_in;
         final_ff  <= final_in;
         padded_ff <= padded_in;
         spill_ff  <= spill_in;
      end
      win_ff <= win_in;
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("rsp while accepting");
   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word_index == 3'd0) else $error("emit not at word 0");
   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha_pkg::ST_FOLD) |-> $past(round_ff) == 6'd63) else $error("short block");
`endif

endmodule
